/* rtl/core/sspp_pkg.sv */
// ----------------------------------------------------------------------------
// sspp_pkg
// Shared types, register codes, reset values and the cos/sin table.
// ----------------------------------------------------------------------------
package sspp_pkg;

  typedef struct packed {
    logic [13:0] frame_count;
    logic [9:0]  particle_index;
  } item_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [7:0]         source_x;
    logic [6:0]         source_y;
    logic               visible;
  } result_t;

  typedef enum logic [2:0] {
    REG_PARTICLE_COUNT  = 3'd0,
    REG_DIVISIONS       = 3'd1,
    REG_RADIUS_STEP     = 3'd2,
    REG_ANGLE_STEP      = 3'd3,
    REG_START_RADIUS    = 3'd4,
    REG_END_RADIUS      = 3'd5,
    REG_START_DELAY     = 3'd6,
    REG_CENTER_POSITION = 3'd7
  } reg_idx_e;

  localparam logic [9:0]  RST_PARTICLE_COUNT  = 10'd100;
  localparam logic [8:0]  RST_DIVISIONS       = 9'd3;
  localparam logic [9:0]  RST_RADIUS_STEP     = 10'd7;
  localparam logic [8:0]  RST_ANGLE_STEP      = 9'd15;
  localparam logic [11:0] RST_START_RADIUS    = 12'd0;
  localparam logic [11:0] RST_END_RADIUS      = 12'd1000;
  localparam logic [13:0] RST_START_DELAY     = 14'd0;
  localparam logic [31:0] RST_CENTER_POSITION = 32'h0140_00F0;

  localparam int ANGLE_FULL = 360;
  localparam int ANGLE_HALF = 180;
  localparam real TWO_PI    = 3.14159 * 2.0;

  typedef logic signed [9:0] trig_half_t [ANGLE_HALF];

  function automatic trig_half_t build_trig(input int base, input bit use_sin);
    trig_half_t tab;
    real a;
    real v;
    for (int i = 0; i < ANGLE_HALF; i++) begin
      a = real'(base + i) * TWO_PI / 360.0;
      v = use_sin ? $sin(a) : $cos(a);
      tab[i] = 10'($rtoi(v * 256.0 + 0.5));
    end
    return tab;
  endfunction

  localparam trig_half_t COS_LO = build_trig(0, 1'b0);
  localparam trig_half_t COS_HI = build_trig(ANGLE_HALF, 1'b0);
  localparam trig_half_t SIN_LO = build_trig(0, 1'b1);
  localparam trig_half_t SIN_HI = build_trig(ANGLE_HALF, 1'b1);

endpackage

/* rtl/core/spiral_particle_sprite_placer.sv */
// ----------------------------------------------------------------------------
// spiral_particle_sprite_placer
// Places one particle of a spiralling sprite swarm per item.
// ----------------------------------------------------------------------------
// A new item may be started in every cycle (busy_o stays low) and its result
// appears on result_o with result_valid_o high for one cycle; the receiver cannot
// stall, so results must be taken when shown. The result passes through the
// phase and product stages, the 25-stage radius modulo divider and its
// alignment delay to the merge, then lookup, scaling and output registers.
module spiral_particle_sprite_placer #(
  parameter int SPRITE_W    = 32,
  parameter int SPRITE_H    = 32,
  parameter int PART_KINDS  = 4,
  parameter int ANGLE_KINDS = 8,
  parameter int SCREEN_W    = 640,
  parameter int SCREEN_H    = 480
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  sspp_pkg::item_t          item_i,
  output logic                     result_valid_o,
  output sspp_pkg::result_t        result_o,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [4:0]               paddr_i,
  input  logic [31:0]              pwdata_i,
  output logic [31:0]              prdata_o,
  output logic                     pready_o
);
  import sspp_pkg::*;

  localparam int PKW  = $clog2(PART_KINDS + 1);
  localparam int ADIV = (ANGLE_KINDS > 1) ? ANGLE_FULL / ANGLE_KINDS : 1;
  localparam int LAT  = 35;
  localparam int PK_SH = 14;
  localparam logic [14:0] PK_RECIP = 15'(((1 << PK_SH) + PART_KINDS - 1) / PART_KINDS);

  localparam logic signed [19:0] XMIN = 20'(-SPRITE_W);
  localparam logic signed [19:0] YMIN = 20'(-SPRITE_H);
  localparam logic signed [19:0] XMAX = 20'(SCREEN_W + SPRITE_W);
  localparam logic signed [19:0] YMAX = 20'(SCREEN_H + SPRITE_H);
  localparam logic signed [19:0] XOFS = 20'(SPRITE_W / 2);
  localparam logic signed [19:0] YOFS = 20'(SPRITE_H / 2);

  typedef logic [7:0] sx_half_t [ANGLE_HALF];

  function automatic sx_half_t build_sx(input int base);
    sx_half_t tab;
    int th;
    int cls;
    for (int i = 0; i < ANGLE_HALF; i++) begin
      th  = base + i;
      cls = ((th + ADIV / 2) % ANGLE_FULL) / ADIV;
      tab[i] = (ANGLE_KINDS > 1) ? 8'((SPRITE_W * (cls % ANGLE_KINDS)) & 255) : 8'd0;
    end
    return tab;
  endfunction

  localparam sx_half_t SX_LO = build_sx(0);
  localparam sx_half_t SX_HI = build_sx(ANGLE_HALF);

  // configuration registers
  logic [9:0]  pcount_q;
  logic [8:0]  divs_q;
  logic [9:0]  rstep_q;
  logic [8:0]  astep_q;
  logic [11:0] srad_q;
  logic [11:0] erad_q;
  logic [13:0] sdelay_q;
  logic [31:0] center_q;
  logic        wr_en;

  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign busy_o   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= RST_PARTICLE_COUNT;
      divs_q   <= RST_DIVISIONS;
      rstep_q  <= RST_RADIUS_STEP;
      astep_q  <= RST_ANGLE_STEP;
      srad_q   <= RST_START_RADIUS;
      erad_q   <= RST_END_RADIUS;
      sdelay_q <= RST_START_DELAY;
      center_q <= RST_CENTER_POSITION;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr_i[4:2]))
        REG_PARTICLE_COUNT:  pcount_q <= pwdata_i[9:0];
        REG_DIVISIONS:       divs_q   <= pwdata_i[8:0];
        REG_RADIUS_STEP:     rstep_q  <= pwdata_i[9:0];
        REG_ANGLE_STEP:      astep_q  <= pwdata_i[8:0];
        REG_START_RADIUS:    srad_q   <= pwdata_i[11:0];
        REG_END_RADIUS:      erad_q   <= pwdata_i[11:0];
        REG_START_DELAY:     sdelay_q <= pwdata_i[13:0];
        REG_CENTER_POSITION: center_q <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr_i[4:2]))
      REG_PARTICLE_COUNT:  prdata_o = {22'b0, pcount_q};
      REG_DIVISIONS:       prdata_o = {23'b0, divs_q};
      REG_RADIUS_STEP:     prdata_o = {22'b0, rstep_q};
      REG_ANGLE_STEP:      prdata_o = {23'b0, astep_q};
      REG_START_RADIUS:    prdata_o = {20'b0, srad_q};
      REG_END_RADIUS:      prdata_o = {20'b0, erad_q};
      REG_START_DELAY:     prdata_o = {18'b0, sdelay_q};
      REG_CENTER_POSITION: prdata_o = center_q;
      default:             prdata_o = '0;
    endcase
  end

  // stage 1: phase
  logic               s1_vld_q;
  logic signed [15:0] s1_k_q;
  logic [9:0]         s1_idx_q;
  logic signed [15:0] s1_k_d;

  assign s1_k_d = $signed({2'b0, item_i.frame_count}) + $signed({6'b0, item_i.particle_index})
                - $signed({2'b0, sdelay_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_k_q   <= s1_k_d;
    s1_idx_q <= item_i.particle_index;
  end

  // stage 2: products and effective divisors
  logic           s2_vld_q, s2_bad_q;
  logic [24:0]    s2_prodr_q;
  logic [23:0]    s2_proda_q;
  logic [18:0]    s2_sp_q;
  logic [10:0]    s2_idx1_q;
  logic [PKW-1:0] s2_pk_q;
  logic [11:0]    s2_span_q;
  logic [9:0]     s2_cnt_q;
  logic [8:0]     s2_div_q;
  logic [9:0]     cnt_eff;
  logic [8:0]     div_eff;
  logic [11:0]    span_abs;
  logic [11:0]    span_eff;
  logic [14:0]    kp;
  logic [24:0]    pk_prod;
  logic [9:0]     pk_quo;
  logic [9:0]     pk_back;
  logic [9:0]     pk_low;

  assign cnt_eff  = (pcount_q == '0) ? 10'd1 : pcount_q;
  assign div_eff  = (divs_q == '0) ? 9'd1 : divs_q;
  assign span_abs = (erad_q >= srad_q) ? (erad_q - srad_q) : (srad_q - erad_q);
  assign span_eff = (span_abs == '0) ? 12'd1 : span_abs;
  assign kp       = s1_k_q[14:0];

  // particle kind by reciprocal multiply
  assign pk_prod  = {15'b0, s1_idx_q} * {10'b0, PK_RECIP};
  assign pk_quo   = pk_prod[PK_SH+9:PK_SH];
  assign pk_back  = 10'({4'b0, pk_quo} * 14'(PART_KINDS));
  assign pk_low   = s1_idx_q - pk_back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_bad_q   <= (s1_idx_q >= cnt_eff) | s1_k_q[15];
    s2_prodr_q <= 25'({10'b0, kp} * {15'b0, rstep_q});
    s2_proda_q <= 24'({9'b0, kp} * {15'b0, astep_q});
    s2_sp_q    <= 19'({9'b0, s1_idx_q} * 19'(ANGLE_FULL));
    s2_idx1_q  <= {1'b0, s1_idx_q} + 11'd1;
    s2_pk_q    <= pk_low[PKW-1:0];
    s2_span_q  <= span_eff;
    s2_cnt_q   <= cnt_eff;
    s2_div_q   <= div_eff;
  end

  // divider branches
  logic [11:0] rmod_rem, rmod_al;
  logic [8:0]  amod_rem, amod_al;
  logic [18:0] spr_quo;
  logic [8:0]  spr_al;
  logic [8:0]  dq_quo;
  logic [10:0] idx1_al;
  logic [18:0] f_prod_q;
  logic [8:0]  fmod_rem, fmod_al;
  logic [PKW-1:0] pk_al;
  logic [1:0]  ctl_al;

  sspp_div #(.N(25), .D(12)) u_rmod (
    .clk_i, .num_i(s2_prodr_q), .den_i(s2_span_q), .quo_o(), .rem_o(rmod_rem)
  );
  sspp_mod360 u_amod (
    .clk_i, .num_i(s2_proda_q), .rem_o(amod_rem)
  );
  sspp_div #(.N(19), .D(10)) u_spr (
    .clk_i, .num_i(s2_sp_q), .den_i(s2_cnt_q), .quo_o(spr_quo), .rem_o()
  );
  sspp_div #(.N(9), .D(9)) u_dq (
    .clk_i, .num_i(9'(ANGLE_FULL)), .den_i(s2_div_q), .quo_o(dq_quo), .rem_o()
  );
  sspp_mod360 u_fmod (
    .clk_i, .num_i({5'b0, f_prod_q}), .rem_o(fmod_rem)
  );

  sspp_dly #(.W(11), .DEPTH(9)) u_idx1_dly (
    .clk_i, .rst_ni, .d_i(s2_idx1_q), .q_o(idx1_al)
  );

  always_ff @(posedge clk_i) begin
    f_prod_q <= 19'(dq_quo * idx1_al);
  end

  sspp_dly #(.W(12), .DEPTH(4)) u_rmod_dly (
    .clk_i, .rst_ni, .d_i(rmod_rem), .q_o(rmod_al)
  );
  sspp_dly #(.W(9), .DEPTH(27)) u_amod_dly (
    .clk_i, .rst_ni, .d_i(amod_rem), .q_o(amod_al)
  );
  sspp_dly #(.W(9), .DEPTH(10)) u_spr_dly (
    .clk_i, .rst_ni, .d_i(spr_quo[8:0]), .q_o(spr_al)
  );
  sspp_dly #(.W(9), .DEPTH(17)) u_fmod_dly (
    .clk_i, .rst_ni, .d_i(fmod_rem), .q_o(fmod_al)
  );
  sspp_dly #(.W(PKW), .DEPTH(29)) u_pk_dly (
    .clk_i, .rst_ni, .d_i(s2_pk_q), .q_o(pk_al)
  );
  sspp_dly #(.W(2), .DEPTH(29)) u_ctl_dly (
    .clk_i, .rst_ni, .d_i({s2_vld_q, s2_bad_q}), .q_o(ctl_al)
  );

  // merge: radius and angle
  logic           m1_vld_q, m1_bad_q;
  logic [11:0]    m1_rad_q;
  logic [8:0]     m1_th_q;
  logic [PKW-1:0] m1_pk_q;
  logic [12:0]    rad_sum, rad_diff;
  logic [11:0]    rad_d;
  logic [8:0]     e_use;
  logic [10:0]    th_sum;
  logic [8:0]     th_d;

  assign rad_sum  = {1'b0, srad_q} + {1'b0, rmod_al};
  assign rad_diff = {1'b0, srad_q} - {1'b0, rmod_al};
  assign rad_d    = (erad_q >= srad_q) ? rad_sum[11:0] :
                    (rad_diff[12] ? 12'd0 : rad_diff[11:0]);
  assign e_use    = ctl_al[0] ? 9'd0 : spr_al;
  assign th_sum   = 11'(amod_al) + 11'(e_use) + 11'(fmod_al);

  always_comb begin
    if (th_sum >= 11'(2 * ANGLE_FULL)) begin
      th_d = 9'(th_sum - 11'(2 * ANGLE_FULL));
    end else if (th_sum >= 11'(ANGLE_FULL)) begin
      th_d = 9'(th_sum - 11'(ANGLE_FULL));
    end else begin
      th_d = th_sum[8:0];
    end
  end

  // table lookup
  logic              m2_vld_q, m2_bad_q;
  logic [11:0]       m2_rad_q;
  logic signed [9:0] m2_cos_q, m2_sin_q;
  logic [7:0]        m2_sx_q;
  logic [PKW-1:0]    m2_pk_q;
  logic              th_hi;
  logic [7:0]        th_idx;

  assign th_hi  = (m1_th_q >= 9'(ANGLE_HALF));
  assign th_idx = th_hi ? 8'(m1_th_q - 9'(ANGLE_HALF)) : m1_th_q[7:0];

  // scaling products
  logic               m3_vld_q, m3_bad_q;
  logic signed [22:0] m3_px_q, m3_py_q;
  logic [7:0]         m3_sx_q;
  logic [PKW-1:0]     m3_pk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= ctl_al[1];
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_bad_q <= ctl_al[0];
    m1_rad_q <= rad_d;
    m1_th_q  <= th_d;
    m1_pk_q  <= pk_al;
    m2_bad_q <= m1_bad_q;
    m2_rad_q <= m1_rad_q;
    m2_cos_q <= th_hi ? COS_HI[th_idx] : COS_LO[th_idx];
    m2_sin_q <= th_hi ? SIN_HI[th_idx] : SIN_LO[th_idx];
    m2_sx_q  <= th_hi ? SX_HI[th_idx] : SX_LO[th_idx];
    m2_pk_q  <= m1_pk_q;
    m3_bad_q <= m2_bad_q;
    m3_px_q  <= 23'(m2_cos_q) * 23'($signed({1'b0, m2_rad_q}));
    m3_py_q  <= 23'(m2_sin_q) * 23'($signed({1'b0, m2_rad_q}));
    m3_sx_q  <= m2_sx_q;
    m3_pk_q  <= m2_pk_q;
  end

  // position, clip and output register
  logic signed [22:0] px_adj, py_adj;
  logic signed [22:0] dx_full, dy_full;
  logic signed [19:0] cx, cy, pos_x, pos_y;
  logic               in_clip, vis;
  logic [6:0]         sy_val;
  result_t            res_d;
  result_t            res_q;
  logic               res_vld_q;

  assign px_adj  = m3_px_q + (m3_px_q[22] ? 23'sd255 : 23'sd0);
  assign py_adj  = m3_py_q + (m3_py_q[22] ? 23'sd255 : 23'sd0);
  assign dx_full = px_adj >>> 8;
  assign dy_full = py_adj >>> 8;
  assign cx      = 20'($signed(center_q[31:16]));
  assign cy      = 20'($signed(center_q[15:0]));
  assign pos_x   = cx + 20'(dx_full) - XOFS;
  assign pos_y   = cy + 20'(dy_full) - YOFS;
  assign in_clip = (pos_x >= XMIN) && (pos_y >= YMIN) && (pos_x < XMAX) && (pos_y < YMAX);
  assign vis     = ~m3_bad_q & in_clip;
  assign sy_val  = 7'(16'(SPRITE_H) * 16'(m3_pk_q));

  always_comb begin
    res_d.screen_x = m3_bad_q ? 16'sd0 : pos_x[15:0];
    res_d.screen_y = m3_bad_q ? 16'sd0 : pos_y[15:0];
    res_d.source_x = vis ? m3_sx_q : 8'd0;
    res_d.source_y = vis ? sy_val : 7'd0;
    res_d.visible  = vis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching item");

  a_hidden_no_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.visible) |->
      (result_o.source_x == 8'd0 && result_o.source_y == 7'd0))
    else $error("hidden sprite carries a source offset");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m1_vld_q && !m1_bad_q) |-> (m1_th_q < 9'(ANGLE_FULL)))
    else $error("angle out of range");

endmodule

/* rtl/core/sspp_div.sv */
// ----------------------------------------------------------------------------
// sspp_div
// Pipelined restoring divider, one quotient bit per stage, and a
// two-stage modulo-360 unit built on a reciprocal multiply.
// ----------------------------------------------------------------------------
module sspp_div #(
  parameter int N = 8,
  parameter int D = 8
) (
  input  logic         clk_i,
  input  logic [N-1:0] num_i,
  input  logic [D-1:0] den_i,
  output logic [N-1:0] quo_o,
  output logic [D-1:0] rem_o
);

  logic [N-1:0] num_q [N];
  logic [D-1:0] den_q [N];
  logic [D-1:0] rem_q [N];
  logic [N-1:0] quo_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [N-1:0] num_in;
    logic [N-1:0] quo_in;
    logic [D-1:0] den_in;
    logic [D-1:0] rem_in;
    logic [D:0]   trial;
    logic         take;

    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = {rem_in, num_in[N-1-s]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      num_q[s] <= num_in;
      den_q[s] <= den_in;
      rem_q[s] <= take ? D'(trial - {1'b0, den_in}) : trial[D-1:0];
      quo_q[s] <= N'({quo_in, take});
    end
  end

  assign quo_o = quo_q[N-1];
  assign rem_o = rem_q[N-1];

endmodule

// ----------------------------------------------------------------------------
// sspp_mod360
// Remainder of a 24-bit value by 360: the low three bits pass
// through and the rest is reduced modulo 45 by a reciprocal multiply.
// ----------------------------------------------------------------------------
module sspp_mod360 (
  input  logic        clk_i,
  input  logic [23:0] num_i,
  output logic [8:0]  rem_o
);

  localparam logic [23:0] RECIP45 = 24'd11930465;
  localparam logic [20:0] DIV45   = 21'd45;

  logic [20:0] y;
  logic [44:0] prod_q;
  logic [20:0] y_q;
  logic [2:0]  lo_q;
  logic [15:0] quo;
  logic [20:0] back;
  logic [20:0] r45;
  logic [8:0]  rem_q;

  assign y = num_i[23:3];

  always_ff @(posedge clk_i) begin
    prod_q <= {24'b0, y} * {21'b0, RECIP45};
    y_q    <= y;
    lo_q   <= num_i[2:0];
  end

  assign quo  = prod_q[44:29];
  assign back = 21'({5'b0, quo} * DIV45);
  assign r45  = y_q - back;

  always_ff @(posedge clk_i) begin
    rem_q <= {r45[5:0], lo_q};
  end

  assign rem_o = rem_q;

endmodule

/* rtl/core/sspp_dly.sv */
// ----------------------------------------------------------------------------
// sspp_dly
// Fixed-length register delay line for pipeline alignment.
// ----------------------------------------------------------------------------
module sspp_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) pipe_q[i] <= '0;
    end else begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule
